/* sv/rpn_pkg.sv */
// Shared types and constants for the RPN stack evaluator.
package rpn_pkg;

  // Width of the operand and result ports
  localparam int unsigned IO_W = 32;

  // Token kinds on func
  localparam logic [2:0] FUNC_PUSH = 3'd0;
  localparam logic [2:0] FUNC_ADD  = 3'd1;
  localparam logic [2:0] FUNC_SUB  = 3'd2;
  localparam logic [2:0] FUNC_MUL  = 3'd3;
  localparam logic [2:0] FUNC_DIV  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef enum logic [2:0] {
    AP_IDLE,
    AP_ARITH,
    AP_NEG_A,
    AP_NEG_B,
    AP_LOOP,
    AP_FIX
  } alu_phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_RIGHT,
    S_RD_LEFT,
    S_EXEC,
    S_FINISH,
    S_RD_TOP,
    S_EMIT
  } seq_state_t;

endpackage

/* sv/rpn_stack_mem.sv */
// Operand stack storage: one write port, one registered read port.
module rpn_stack_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/rpn_alu.sv */
// Iterative arithmetic unit: one shared adder for add, sub, shift-add multiply
// and restoring divide.
module rpn_alu
  import rpn_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  alu_cmd_t         cmd,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int unsigned CW = $clog2(WIDTH);

  alu_phase_t       phase, phase_next;
  alu_op_t          op, op_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [WIDTH-1:0] x, x_next;
  logic [WIDTH-1:0] y, y_next;
  logic [WIDTH-1:0] z, z_next;
  logic             sign_a, sign_a_next;
  logic             sign_b, sign_b_next;
  logic             done_next;

  // shared adder
  logic [WIDTH-1:0] p, q;
  logic             cin;
  logic [WIDTH:0]   sum;

  assign sum = {1'b0, p} + {1'b0, q} + {{WIDTH{1'b0}}, cin};

  always_comb begin
    p   = '0;
    q   = '0;
    cin = 1'b0;
    unique case (phase)
      AP_ARITH: begin
        p   = x;
        q   = (op == ALU_SUB) ? ~y : y;
        cin = (op == ALU_SUB);
      end
      AP_NEG_A, AP_FIX: begin
        q   = ~z;
        cin = 1'b1;
      end
      AP_NEG_B: begin
        q   = ~y;
        cin = 1'b1;
      end
      AP_LOOP: begin
        if (op == ALU_MUL) begin
          p = x;
          q = z[0] ? y : '0;
        end else begin
          // partial remainder shifted left with next dividend bit; remainder
          // stays below the divisor magnitude, so its top bit is clear
          p   = {x[WIDTH-2:0], z[WIDTH-1]};
          q   = ~y;
          cin = 1'b1;
        end
      end
      AP_IDLE: ;
      default: ;
    endcase
  end

  always_comb begin
    phase_next  = phase;
    op_next     = op;
    cnt_next    = cnt;
    x_next      = x;
    y_next      = y;
    z_next      = z;
    sign_a_next = sign_a;
    sign_b_next = sign_b;
    done_next   = 1'b0;
    unique case (phase)
      AP_IDLE: begin
        if (cmd.start) begin
          op_next     = cmd.op;
          cnt_next    = '0;
          sign_a_next = a[WIDTH-1];
          sign_b_next = b[WIDTH-1];
          unique case (cmd.op)
            ALU_ADD, ALU_SUB: begin
              x_next     = a;
              y_next     = b;
              phase_next = AP_ARITH;
            end
            ALU_MUL: begin
              x_next     = '0;
              y_next     = a;
              z_next     = b;
              phase_next = AP_LOOP;
            end
            ALU_DIV: begin
              x_next     = '0;
              y_next     = b;
              z_next     = a;
              phase_next = AP_NEG_A;
            end
            default: ;
          endcase
        end
      end
      AP_ARITH: begin
        x_next     = sum[WIDTH-1:0];
        done_next  = 1'b1;
        phase_next = AP_IDLE;
      end
      AP_NEG_A: begin
        if (sign_a) begin
          z_next = sum[WIDTH-1:0];
        end
        phase_next = AP_NEG_B;
      end
      AP_NEG_B: begin
        if (sign_b) begin
          y_next = sum[WIDTH-1:0];
        end
        phase_next = AP_LOOP;
      end
      AP_LOOP: begin
        cnt_next = cnt + CW'(1);
        if (op == ALU_MUL) begin
          x_next = sum[WIDTH-1:0];
          y_next = y << 1;
          z_next = z >> 1;
        end else begin
          x_next = sum[WIDTH] ? sum[WIDTH-1:0] : p;
          z_next = {z[WIDTH-2:0], sum[WIDTH]};
        end
        if (cnt == CW'(WIDTH - 1)) begin
          if (op == ALU_MUL) begin
            done_next  = 1'b1;
            phase_next = AP_IDLE;
          end else begin
            phase_next = AP_FIX;
          end
        end
      end
      AP_FIX: begin
        if (sign_a ^ sign_b) begin
          z_next = sum[WIDTH-1:0];
        end
        done_next  = 1'b1;
        phase_next = AP_IDLE;
      end
      default: phase_next = AP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= AP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    cnt    <= cnt_next;
    x      <= x_next;
    y      <= y_next;
    z      <= z_next;
    sign_a <= sign_a_next;
    sign_b <= sign_b_next;
  end

  assign result = (op == ALU_DIV) ? z : x;

endmodule

/* sv/rpn_stack_evaluator_top.sv */
// Top level of the RPN stack evaluator: token sequencer, stack and shared ALU.
//
// Input channel (in_valid / in_stall): one token per transfer. func selects
// push (operand_value) or add, subtract, multiply, divide on the top two
// entries; end_of_expression marks the final token of an expression.
// Output channel (out_valid / out_stall): one transfer per expression carrying
// the top of stack (result_value) and the first error seen (status).
//
// The sequencer takes no new token until the current one is finished. The
// shift-add multiply and restoring divide loop in the shared ALU, one bit per
// cycle; the single stack read port reads each popped operand in its own
// state, the right one and then the left. An end mark on an empty stack
// emits zero directly; otherwise it reads the top of the stack, then emits.
//
// Reset clears the sequencer, the stack count and the sticky status; stack
// contents are not cleared. The result sits in an output register, so the
// next token is taken while it waits. A second result waits in the emit state
// while the receiver stalls, holding in_stall high.
module rpn_stack_evaluator_top
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             func,
  input  logic signed [IO_W-1:0] operand_value,
  input  logic                   end_of_expression,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [IO_W-1:0] result_value,
  output logic [1:0]             status
);

  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CNTW = $clog2(STACK_DEPTH + 1);

  seq_state_t state, state_next;

  logic [CNTW-1:0] cnt, cnt_next;
  logic [1:0]      err, err_next;

  // latched token
  logic [2:0]             tok_func;
  logic signed [IO_W-1:0] tok_value;
  logic                   tok_last;
  alu_op_t                tok_op;
  logic                   tok_is_op;

  logic [DATA_WIDTH-1:0] b_reg, b_next;
  logic [DATA_WIDTH-1:0] res_hold, res_next;
  logic                  load_out;

  // stack port
  logic                  wr_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  // ALU
  alu_cmd_t              alu_cmd;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_result;

  logic [AW-1:0] top_idx, next_idx, push_idx;
  logic          in_xfer;

  assign top_idx  = AW'(cnt - CNTW'(1));
  assign next_idx = AW'(cnt - CNTW'(2));
  assign push_idx = AW'(cnt);

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // left operand comes straight off the read port, right from b_reg
  rpn_alu #(
    .WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .a      (rd_data),
    .b      (b_reg),
    .done   (alu_done),
    .result (alu_result)
  );

  always_comb begin
    tok_is_op = (tok_func == FUNC_ADD) || (tok_func == FUNC_SUB) ||
                (tok_func == FUNC_MUL) || (tok_func == FUNC_DIV);
    unique case (tok_func)
      FUNC_SUB: tok_op = ALU_SUB;
      FUNC_MUL: tok_op = ALU_MUL;
      FUNC_DIV: tok_op = ALU_DIV;
      default:  tok_op = ALU_ADD;
    endcase
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    err_next      = err;
    b_next        = b_reg;
    res_next      = res_hold;
    load_out      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = next_idx;
    wr_data       = alu_result;
    rd_addr       = top_idx;
    alu_cmd.start = 1'b0;
    alu_cmd.op    = tok_op;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (tok_func == FUNC_PUSH) begin
          if (cnt == CNTW'(STACK_DEPTH)) begin
            // full stack: value dropped
            if (err == ST_OK) err_next = ST_OVER;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = push_idx;
            wr_data  = DATA_WIDTH'(tok_value);
            cnt_next = cnt + CNTW'(1);
          end
          state_next = S_FINISH;
        end else if (tok_is_op) begin
          if (cnt < CNTW'(2)) begin
            if (err == ST_OK) err_next = ST_UNDER;
            state_next = S_FINISH;
          end else begin
            rd_addr    = top_idx;
            state_next = S_RD_RIGHT;
          end
        end else begin
          // unknown kind leaves the stack alone
          state_next = S_FINISH;
        end
      end
      S_RD_RIGHT: begin
        b_next     = rd_data;
        rd_addr    = next_idx;
        state_next = S_RD_LEFT;
      end
      S_RD_LEFT: begin
        if (tok_op == ALU_DIV && b_reg == '0) begin
          // divide by zero: pop both, push zero
          if (err == ST_OK) err_next = ST_DIVZ;
          wr_en      = 1'b1;
          wr_data    = '0;
          cnt_next   = cnt - CNTW'(1);
          state_next = S_FINISH;
        end else begin
          alu_cmd.start = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_done) begin
          wr_en      = 1'b1;
          cnt_next   = cnt - CNTW'(1);
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!tok_last) begin
          state_next = S_IDLE;
        end else if (cnt == '0) begin
          if (err == ST_OK) err_next = ST_UNDER;
          res_next   = '0;
          state_next = S_EMIT;
        end else begin
          rd_addr    = top_idx;
          state_next = S_RD_TOP;
        end
      end
      S_RD_TOP: begin
        res_next   = rd_data;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          cnt_next   = '0;
          err_next   = ST_OK;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      err   <= err_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tok_func  <= func;
      tok_value <= operand_value;
      tok_last  <= end_of_expression;
    end
    b_reg    <= b_next;
    res_hold <= res_next;
    if (load_out) begin
      result_value <= IO_W'(res_hold);
      status       <= err;
    end
  end

  // stack count never runs past the depth
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNTW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // an emitted result leaves an empty stack and clean status
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (cnt == '0 && err == ST_OK && out_valid))
    else $error("stack not cleared after result");

  // first error sticks until the result is emitted
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK && !load_out) |=> err == $past(err))
    else $error("sticky status changed");

  // ALU completion only while the sequencer waits for it
  a_alu_done: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == S_EXEC)
    else $error("ALU done outside execute");

endmodule
